### hw/rtl/median_filter_3x3_assert.svh
// ----------------------------------------------------------------------------
// median_filter_3x3 assertion macros
// concurrent property wrappers on aclk, used by the checker file
// ----------------------------------------------------------------------------
`ifndef MEDIAN_FILTER_3X3_ASSERT_SVH
`define MEDIAN_FILTER_3X3_ASSERT_SVH

// same-cycle implication, off during reset
`define MF3_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("median filter property violated");

// next-cycle implication, off during reset
`define MF3_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("median filter property violated");

// next-cycle implication, live during reset as well
`define MF3_ASSERT_NEXT_ALWAYS(label, ante, cons) \
    label: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error("median filter reset property violated");

`endif

### hw/rtl/mf3_pkg.sv
// ----------------------------------------------------------------------------
// mf3_pkg
// types and constants shared by the 3x3 median filter modules
// ----------------------------------------------------------------------------
package mf3_pkg;

    localparam int PIX_W      = 8;
    localparam int ROW_W      = 16;
    localparam int OUT_COL_W  = 10;
    localparam int M_DATA_W   = 40;
    localparam int S_DATA_W   = 8;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int WIDTH_W    = 11;
    localparam int SLOTS      = 3;
    localparam int WIN_TAPS   = 6;
    localparam int NB_TAPS    = 9;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    localparam logic [WIDTH_W-1:0] WIDTH_RESET  = 11'd1024;
    localparam logic [ROW_W-1:0]   HEIGHT_RESET = 16'd1024;

    typedef logic [PIX_W-1:0] pixel_t;

    typedef struct packed {
        logic                 frame_end;
        logic [OUT_COL_W-1:0] col;
        logic [ROW_W-1:0]     row;
        pixel_t               pix;
    } result_t;

    typedef struct packed {
        logic diag_valid;   // result for (r-1,c-1)
        logic interior;     // that result is a true median
        logic above_valid;  // last column of the row above
        logic last_row;
        logic last_col;
    } flags_t;

endpackage

### hw/rtl/median_filter_3x3.sv
// ----------------------------------------------------------------------------
// median_filter_3x3
// streaming 3x3 median filter for 8-bit grayscale frames in raster order
// ----------------------------------------------------------------------------
// Pixels enter on the s_ channel, one word per pixel; results leave on the
// m_ channel with pixel, row and column in m_tdata and m_tlast on the final
// result of a frame. Interior pixels get the median of their neighbourhood,
// border pixels pass through unchanged.
// A pixel that completes a result is registered in the read stage when it
// is accepted, while the line store is read; the median is then formed and
// loaded into the output register as soon as that register is free.
// Throughput: one pixel per cycle while m_tready stays high and each pixel
// yields at most one result. A last-column pixel below the first row yields
// two results and a last-row pixel up to three; the port sends one word per
// cycle while m_tready is high, so s_tready drops while extra results drain.
// Reset: position and window clear, configuration returns to 1024 x 1024,
// the line stores keep their contents; unwritten data never reaches a result.
// When m_tready is low the output word holds; one more pixel is taken into
// the read stage, then s_tready drops until the output frees.
// Users write configuration on cfg_we only with the pipeline empty; not enforced.
// ----------------------------------------------------------------------------
module median_filter_3x3 #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [mf3_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mf3_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [mf3_pkg::S_DATA_W-1:0]     s_tdata,   // pixel_in
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [mf3_pkg::M_DATA_W-1:0]     m_tdata,   // pixel_out, out_row, out_col
    output logic                             m_tlast    // frame_end
);

    localparam int AW    = $clog2(MAX_WIDTH);
    localparam int CNT_W = (AW > mf3_pkg::OUT_COL_W) ? AW : mf3_pkg::OUT_COL_W;
    localparam int WW    = CNT_W + 1;
    localparam int RW    = mf3_pkg::ROW_W;

    // configuration
    logic [mf3_pkg::WIDTH_W-1:0] width_reg;
    logic [RW-1:0]               height_reg;
    logic [WW-1:0]               width_ext, col_last;
    logic [RW-1:0]               row_last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= mf3_pkg::WIDTH_RESET;
            height_reg <= mf3_pkg::HEIGHT_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                mf3_pkg::REG_IMAGE_WIDTH: begin
                    width_reg <= cfg_wdata[mf3_pkg::WIDTH_W-1:0];
                end
                mf3_pkg::REG_IMAGE_HEIGHT: begin
                    height_reg <= cfg_wdata[RW-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign width_ext = WW'(width_reg);

    always_comb begin
        if (width_ext < WW'(3)) begin
            col_last = WW'(2);
        end else if (width_ext > WW'(MAX_WIDTH)) begin
            col_last = WW'(MAX_WIDTH - 1);
        end else begin
            col_last = width_ext - WW'(1);
        end
        if (height_reg < RW'(3)) begin
            row_last = RW'(2);
        end else begin
            row_last = height_reg - RW'(1);
        end
    end

    // position of the next pixel
    logic [RW-1:0]    row_reg, row_next;
    logic [CNT_W-1:0] col_reg, col_next;
    logic             accept;
    mf3_pkg::flags_t  flags;

    assign accept = s_tvalid && s_tready;

    always_comb begin
        flags.last_col    = (WW'(col_reg) >= col_last);
        flags.last_row    = (row_reg >= row_last);
        flags.diag_valid  = (row_reg != '0) && (col_reg != '0);
        flags.above_valid = (row_reg != '0) && flags.last_col;
        flags.interior    = (row_reg >= RW'(2)) && (col_reg >= CNT_W'(2))
                            && (WW'(col_reg) <= col_last) && (row_reg <= row_last);
        row_next = row_reg;
        col_next = col_reg + CNT_W'(1);
        if (flags.last_col) begin
            col_next = '0;
            row_next = flags.last_row ? '0 : row_reg + RW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg <= '0;
            col_reg <= '0;
        end else if (accept) begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

    // read stage
    logic                  s1_valid_reg;
    mf3_pkg::pixel_t       s1_pix_reg;
    logic [RW-1:0]         s1_row_reg;
    logic [CNT_W-1:0]      s1_col_reg;
    mf3_pkg::flags_t       s1_flags_reg;
    logic                  emit_free, s1_advance;

    assign s1_advance = s1_valid_reg && emit_free;
    assign s_tready   = !s1_valid_reg || emit_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (accept) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_advance) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_pix_reg   <= s_tdata[mf3_pkg::PIX_W-1:0];
            s1_row_reg   <= row_reg;
            s1_col_reg   <= col_reg;
            s1_flags_reg <= flags;
        end
    end

    // line stores: older row in the high byte, newer row in the low byte
    logic [2*mf3_pkg::PIX_W-1:0] line_rd;
    mf3_pkg::pixel_t             top, mid;

    mf3_ram #(
        .WIDTH (2 * mf3_pkg::PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .aclk    (aclk),
        .wr_en   (s1_advance),
        .wr_addr (s1_col_reg[AW-1:0]),
        .wr_data ({mid, s1_pix_reg}),
        .rd_en   (accept),
        .rd_addr (col_reg[AW-1:0]),
        .rd_data (line_rd)
    );

    assign top = line_rd[2*mf3_pkg::PIX_W-1:mf3_pkg::PIX_W];
    assign mid = line_rd[mf3_pkg::PIX_W-1:0];

    // window: column c-1 (top, mid, new) then column c-2
    mf3_pkg::pixel_t win_reg [mf3_pkg::WIN_TAPS];
    mf3_pkg::pixel_t nb [mf3_pkg::NB_TAPS];
    mf3_pkg::pixel_t median;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < mf3_pkg::WIN_TAPS; k++) begin
                win_reg[k] <= '0;
            end
        end else if (s1_advance) begin
            win_reg[3] <= win_reg[0];
            win_reg[4] <= win_reg[1];
            win_reg[5] <= win_reg[2];
            win_reg[0] <= top;
            win_reg[1] <= mid;
            win_reg[2] <= s1_pix_reg;
        end
    end

    assign nb[0] = win_reg[3];
    assign nb[1] = win_reg[0];
    assign nb[2] = top;
    assign nb[3] = win_reg[4];
    assign nb[4] = win_reg[1];
    assign nb[5] = mid;
    assign nb[6] = win_reg[5];
    assign nb[7] = win_reg[2];
    assign nb[8] = s1_pix_reg;

    mf3_median9 u_median9 (
        .nb     (nb),
        .median (median)
    );

    // results of the pixel in the read stage
    mf3_pkg::result_t          slots [mf3_pkg::SLOTS];
    logic [mf3_pkg::SLOTS-1:0] slot_mask;
    logic [CNT_W-1:0]          col_m1;
    logic [RW-1:0]             row_m1;

    assign col_m1 = s1_col_reg - CNT_W'(1);
    assign row_m1 = s1_row_reg - RW'(1);

    always_comb begin
        slots[0].pix       = s1_flags_reg.interior ? median : win_reg[1];
        slots[0].row       = row_m1;
        slots[0].col       = col_m1[mf3_pkg::OUT_COL_W-1:0];
        slots[0].frame_end = 1'b0;
        slots[1].pix       = mid;
        slots[1].row       = row_m1;
        slots[1].col       = s1_col_reg[mf3_pkg::OUT_COL_W-1:0];
        slots[1].frame_end = 1'b0;
        slots[2].pix       = s1_pix_reg;
        slots[2].row       = s1_row_reg;
        slots[2].col       = s1_col_reg[mf3_pkg::OUT_COL_W-1:0];
        slots[2].frame_end = s1_flags_reg.last_col;
        slot_mask = {s1_flags_reg.last_row, s1_flags_reg.above_valid,
                     s1_flags_reg.diag_valid};
    end

    mf3_emit u_emit (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load_en    (s1_advance),
        .load_mask  (slot_mask),
        .load_slots (slots),
        .free       (emit_free),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

### hw/rtl/mf3_ram.sv
// ----------------------------------------------------------------------------
// mf3_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module mf3_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### hw/rtl/mf3_median9.sv
// ----------------------------------------------------------------------------
// mf3_median9
// nine-input median network: row sorts, then median of the extremes
// ----------------------------------------------------------------------------
module mf3_median9 (
    input  mf3_pkg::pixel_t nb [mf3_pkg::NB_TAPS],
    output mf3_pkg::pixel_t median
);

    function automatic mf3_pkg::pixel_t min2(mf3_pkg::pixel_t a, mf3_pkg::pixel_t b);
        return (a < b) ? a : b;
    endfunction

    function automatic mf3_pkg::pixel_t max2(mf3_pkg::pixel_t a, mf3_pkg::pixel_t b);
        return (a < b) ? b : a;
    endfunction

    function automatic mf3_pkg::pixel_t med3(mf3_pkg::pixel_t a, mf3_pkg::pixel_t b,
                                             mf3_pkg::pixel_t c);
        return max2(min2(a, b), min2(max2(a, b), c));
    endfunction

    mf3_pkg::pixel_t lo [3];
    mf3_pkg::pixel_t md [3];
    mf3_pkg::pixel_t hi [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            lo[k] = min2(min2(nb[3*k], nb[3*k+1]), nb[3*k+2]);
            hi[k] = max2(max2(nb[3*k], nb[3*k+1]), nb[3*k+2]);
            md[k] = med3(nb[3*k], nb[3*k+1], nb[3*k+2]);
        end
        median = med3(max2(max2(lo[0], lo[1]), lo[2]),
                      med3(md[0], md[1], md[2]),
                      min2(min2(hi[0], hi[1]), hi[2]));
    end

endmodule

### hw/rtl/mf3_emit.sv
// ----------------------------------------------------------------------------
// mf3_emit
// output register with three result slots, drained one word per handshake
// ----------------------------------------------------------------------------
module mf3_emit (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           load_en,
    input  logic [mf3_pkg::SLOTS-1:0]      load_mask,
    input  mf3_pkg::result_t               load_slots [mf3_pkg::SLOTS],
    output logic                           free,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [mf3_pkg::M_DATA_W-1:0]   m_tdata,   // pixel_out, out_row, out_col
    output logic                           m_tlast    // frame_end
);

    logic [mf3_pkg::SLOTS-1:0] mask_reg, mask_next, mask_after;
    mf3_pkg::result_t          slot_reg [mf3_pkg::SLOTS];
    mf3_pkg::result_t          head;

    assign m_tvalid   = |mask_reg;
    assign mask_after = (m_tvalid && m_tready) ? (mask_reg & (mask_reg - 1'b1)) : mask_reg;
    assign free       = (mask_after == '0);

    always_comb begin
        mask_next = mask_after;
        if (load_en) begin
            mask_next = load_mask;
        end
    end

    always_comb begin
        head = slot_reg[mf3_pkg::SLOTS-1];
        for (int k = mf3_pkg::SLOTS - 1; k >= 0; k--) begin
            if (mask_reg[k]) begin
                head = slot_reg[k];
            end
        end
    end

    assign m_tdata = {(mf3_pkg::M_DATA_W - mf3_pkg::OUT_COL_W - mf3_pkg::ROW_W
                       - mf3_pkg::PIX_W)'(0), head.col, head.row, head.pix};
    assign m_tlast = head.frame_end;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg <= '0;
        end else begin
            mask_reg <= mask_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_en) begin
            slot_reg <= load_slots;
        end
    end

endmodule

### hw/rtl/mf3_checker.sv
// ----------------------------------------------------------------------------
// mf3_checker
// port-level checks of the median filter, bound to the top level
// ----------------------------------------------------------------------------
`include "median_filter_3x3_assert.svh"

module mf3_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [mf3_pkg::M_DATA_W-1:0]     m_tdata,   // pixel_out, out_row, out_col
    input logic                             m_tlast    // frame_end
);

    // stalled word stays offered and unchanged
    `MF3_ASSERT_NEXT(a_valid_held, m_tvalid && !m_tready, m_tvalid)
    `MF3_ASSERT_NEXT(a_word_held, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tlast))

    // empty output means the pipeline can take a pixel
    `MF3_ASSERT_NOW(a_ready_when_idle, !m_tvalid, s_tready)

    // reset empties the output register
    `MF3_ASSERT_NEXT_ALWAYS(a_reset_clears, !aresetn, !m_tvalid)

endmodule

bind median_filter_3x3 mf3_checker u_mf3_checker (.*);
